// File: rtl/afr_pkg.sv
// Package for the attitude frame receiver: shared types, codes and constants.
// No dependencies.
package afr_pkg;

  localparam logic [7:0]  HEAD_A   = 8'hAA;
  localparam logic [7:0]  HEAD_B   = 8'h55;
  localparam logic [7:0]  TAIL_A   = 8'h55;
  localparam logic [7:0]  TAIL_B   = 8'hAA;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [30:0] RATE_LIMIT_RST = 31'd400000;
  localparam logic [15:0] SEQ_GAP_RST    = 16'd32767;
  localparam logic [31:0] YAW_LIMIT      = 32'h7FFF_FFFF;
  localparam logic [6:0]  SCALE_X100     = 7'd100;

  // Configuration register indices
  localparam logic [0:0] REG_MAX_RATE = 1'b0;
  localparam logic [0:0] REG_MAX_GAP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC,
    ST_YAW,
    ST_RATE,
    ST_FINISH,
    ST_SCAN,
    ST_SHIFT,
    ST_RESULT
  } afr_state_t;

  // Result of one float conversion
  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } afr_fconv_t;

endpackage

// File: rtl/afr_if.sv
// Valid/ready channel interfaces for the attitude frame receiver.
// Depends on nothing.
interface afr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afr_out_if;
  logic        valid;
  logic        ready;
  logic        frame_accepted;
  logic [31:0] yaw_x100;
  logic [31:0] rate_x100;
  logic [15:0] last_sequence;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;
  logic [31:0] lost_frames;
  logic [31:0] dropped_bytes;
  modport source (output valid, output frame_accepted, output yaw_x100, output rate_x100,
                  output last_sequence, output good_frames, output bad_frames,
                  output lost_frames, output dropped_bytes, input ready);
  modport sink (input valid, input frame_accepted, input yaw_x100, input rate_x100,
                input last_sequence, input good_frames, input bad_frames,
                input lost_frames, input dropped_bytes, output ready);
endinterface

interface afr_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/afr_fconv.sv
// Combinational float-to-x100 conversion: one 24x7 multiply then a shift.
// Depends on afr_pkg.
module afr_fconv (
  input  logic [31:0]        bits,
  input  logic [31:0]        limit,
  output afr_pkg::afr_fconv_t res
);
  import afr_pkg::*;

  logic [7:0]  ex;
  logic [30:0] scaled;
  logic [63:0] wide;
  logic [63:0] mag;
  logic [8:0]  sh;
  logic [31:0] m32;

  always_comb begin
    ex     = bits[30:23];
    scaled = {1'b1, bits[22:0]} * SCALE_X100;
    wide   = 64'(scaled);
    mag    = '0;
    sh     = '0;
    res.ok = 1'b1;
    if (ex == 8'hFF) begin
      res.ok = 1'b0;
    end else if (ex != 8'd0) begin
      if (ex >= 8'd150) begin
        sh = 9'(ex) - 9'd150;
        if (sh >= 9'd32 || wide > (64'(limit) >> sh[4:0])) begin
          res.ok = 1'b0;
        end else begin
          mag = wide << sh[4:0];
        end
      end else begin
        sh = 9'd150 - 9'(ex);
        if (sh < 9'd64) begin
          mag = (wide + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
        end
      end
    end
    if (mag > 64'(limit)) res.ok = 1'b0;
    m32       = mag[31:0];
    res.value = bits[31] ? (32'd0 - m32) : m32;
  end
endmodule

// File: rtl/afr_core.sv
// Sequencer for the frame receiver: store, CRC one bit per cycle, float checks,
// counters and resync scan. Depends on afr_pkg and afr_fconv.
module afr_core #(
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [31:0] out_yaw,
  output logic [31:0] out_rate,
  output logic [15:0] out_seq,
  output logic [COUNTER_BITS-1:0] out_good,
  output logic [COUNTER_BITS-1:0] out_bad,
  output logic [COUNTER_BITS-1:0] out_lost,
  output logic [COUNTER_BITS-1:0] out_drop,
  input  logic [30:0] max_rate,
  input  logic [15:0] max_gap
);
  import afr_pkg::*;

  localparam logic [COUNTER_BITS-1:0] CNT_TOP = '1;

  afr_state_t state_r, state_nxt;
  logic [7:0] store_r [16];
  logic [4:0] fill_r;
  logic [15:0] crc_r;
  logic [6:0] crc_cnt_r;
  logic [3:0] scan_r;
  logic [3:0] shift_r;
  logic       seen_r, ok_r;
  logic [15:0] prev_r;
  logic [31:0] yaw_r, rate_r, yaw_tmp_r;
  logic [COUNTER_BITS-1:0] good_r, bad_r, lost_r, drop_r;

  logic [31:0] fbits, flimit;
  afr_fconv_t  fres;
  logic [3:0]  pos;
  logic [7:0]  crc_byte;
  logic        crc_fb;
  logic [15:0] crc_in, crc_step;
  logic [15:0] seq, delta;
  logic        frame_ok_hdr;

  afr_fconv u_fconv (.bits(fbits), .limit(flimit), .res(fres));

  // Saturating add of a small amount
  function automatic logic [COUNTER_BITS-1:0] sat_add(
    input logic [COUNTER_BITS-1:0] a, input logic [16:0] inc);
    logic [COUNTER_BITS:0] s;
    s = {1'b0, a} + (COUNTER_BITS+1)'(inc);
    return s[COUNTER_BITS] ? CNT_TOP : s[COUNTER_BITS-1:0];
  endfunction

  assign pos      = fill_r[3:0];
  assign in_ready = (state_r == ST_IDLE) && !out_valid;
  assign seq      = {store_r[3], store_r[2]};
  assign delta    = seq - prev_r;
  assign frame_ok_hdr = store_r[0] == HEAD_A && store_r[1] == HEAD_B &&
                        store_r[14] == TAIL_A && store_r[15] == TAIL_B;

  // CRC: one bit per cycle, a new byte after every eight bits
  always_comb begin
    crc_byte = store_r[4'(crc_cnt_r[6:3] + 4'd2)];
    crc_in   = (crc_cnt_r[2:0] == 3'd0) ? (crc_r ^ {8'd0, crc_byte}) : crc_r;
    crc_fb   = crc_in[0];
    crc_step = crc_fb ? ((crc_in >> 1) ^ CRC_POLY) : (crc_in >> 1);
  end

  // Pick float operand
  always_comb begin
    if (state_r == ST_RATE) begin
      fbits  = {store_r[11], store_r[10], store_r[9], store_r[8]};
      flimit = {1'b0, max_rate};
    end else begin
      fbits  = {store_r[7], store_r[6], store_r[5], store_r[4]};
      flimit = YAW_LIMIT;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (pos == 4'd15 && fill_r != 5'd0) state_nxt = ST_CRC;
          else state_nxt = ST_RESULT;
        end
      end
      ST_CRC: if (crc_cnt_r == 7'd79) state_nxt = ST_YAW;
      ST_YAW: state_nxt = ST_RATE;
      ST_RATE: state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ok_r ? ST_RESULT : ST_SCAN;
      ST_SCAN: begin
        if (store_r[14] == TAIL_A && store_r[15] == TAIL_B) state_nxt = ST_RESULT;
        else if (scan_r != 4'd0 && store_r[scan_r] == HEAD_A &&
                 store_r[4'(scan_r + 4'd1)] == HEAD_B) state_nxt = ST_SHIFT;
        else if (scan_r == 4'd0) state_nxt = ST_RESULT;
      end
      ST_SHIFT: if (4'(shift_r + scan_r) == 4'd15) state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == ST_RESULT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT) begin
      out_ok   <= ok_r;
      out_yaw  <= yaw_r;
      out_rate <= rate_r;
      out_seq  <= prev_r;
      out_good <= good_r;
      out_bad  <= bad_r;
      out_lost <= lost_r;
      out_drop <= drop_r;
    end
  end

  // Frame store, no reset needed beyond zero content at start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) store_r[i] <= 8'd0;
    end else if (state_r == ST_IDLE && in_valid && in_ready) begin
      if (pos == 4'd0) begin
        if (in_byte == HEAD_A) store_r[0] <= in_byte;
      end else if (pos == 4'd1) begin
        if (in_byte == HEAD_B) store_r[pos] <= in_byte;
        if (in_byte == HEAD_A) store_r[0] <= in_byte;
      end else begin
        store_r[pos] <= in_byte;
      end
    end else if (state_r == ST_SCAN && scan_r == 4'd0 && store_r[15] == HEAD_A &&
                 !(store_r[14] == TAIL_A && store_r[15] == TAIL_B)) begin
      store_r[0] <= HEAD_A;
    end else if (state_r == ST_SHIFT) begin
      store_r[shift_r] <= store_r[4'(shift_r + scan_r)];
    end
  end

  // Control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      crc_r     <= CRC_INIT;
      crc_cnt_r <= '0;
      scan_r    <= '0;
      shift_r   <= '0;
      seen_r    <= 1'b0;
      ok_r      <= 1'b0;
      prev_r    <= '0;
      yaw_r     <= '0;
      rate_r    <= '0;
      yaw_tmp_r <= '0;
      good_r    <= '0;
      bad_r     <= '0;
      lost_r    <= '0;
      drop_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          ok_r      <= 1'b0;
          crc_r     <= CRC_INIT;
          crc_cnt_r <= '0;
          scan_r    <= 4'd14;
          shift_r   <= '0;
          if (in_valid && in_ready) begin
            if (pos == 4'd0) begin
              if (in_byte == HEAD_A) fill_r <= 5'd1;
              else begin
                fill_r <= 5'd0;
                drop_r <= sat_add(drop_r, 17'd1);
              end
            end else if (pos == 4'd1) begin
              if (in_byte == HEAD_B) fill_r <= 5'd2;
              else if (in_byte == HEAD_A) begin
                fill_r <= 5'd1;
                drop_r <= sat_add(drop_r, 17'd1);
              end else begin
                fill_r <= 5'd0;
                drop_r <= sat_add(drop_r, 17'd2);
              end
            end else begin
              fill_r <= 5'({1'b0, pos} + 5'd1);
            end
          end
        end
        ST_CRC: begin
          crc_r     <= crc_step;
          crc_cnt_r <= crc_cnt_r + 7'd1;
        end
        ST_YAW: begin
          ok_r      <= frame_ok_hdr && crc_r == {store_r[13], store_r[12]} && fres.ok;
          yaw_tmp_r <= fres.value;
        end
        ST_RATE: begin
          ok_r <= ok_r && fres.ok;
          if (ok_r && fres.ok) begin
            rate_r <= fres.value;
            yaw_r  <= yaw_tmp_r;
          end
        end
        ST_FINISH: begin
          if (ok_r) begin
            fill_r <= 5'd0;
            seen_r <= 1'b1;
            prev_r <= seq;
            good_r <= sat_add(good_r, 17'd1);
            if (seen_r && delta > 16'd1 && delta <= max_gap)
              lost_r <= sat_add(lost_r, 17'(delta - 16'd1));
          end else begin
            bad_r <= sat_add(bad_r, 17'd1);
          end
        end
        ST_SCAN: begin
          if (store_r[14] == TAIL_A && store_r[15] == TAIL_B) begin
            fill_r <= 5'd0;
          end else if (scan_r != 4'd0 && store_r[scan_r] == HEAD_A &&
                       store_r[4'(scan_r + 4'd1)] == HEAD_B) begin
            fill_r <= 5'd16 - 5'(scan_r);
          end else if (scan_r == 4'd0) begin
            fill_r <= (store_r[15] == HEAD_A) ? 5'd1 : 5'd0;
          end else begin
            scan_r <= scan_r - 4'd1;
          end
        end
        ST_SHIFT: shift_r <= shift_r + 4'd1;
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/attitude_frame_receiver.sv
// Attitude frame receiver: takes one byte per transfer and returns one result per byte.
// Most bytes go straight to their result; the byte that completes a frame first passes
// through the bit-serial CRC, the float checks and, for a rejected frame, the resync
// scan/shift over the 16-byte store. The next byte can be taken in the cycle after the
// result transfer. Depends on afr_pkg, afr_if and afr_core.
module attitude_frame_receiver #(
  parameter int COUNTER_BITS = 32
) (
  input logic clk,
  input logic rst_n,
  afr_in_if.sink    in_ch,
  afr_out_if.source out_ch,
  afr_cfg_if.sink   cfg_ch
);
  import afr_pkg::*;

  logic [30:0] max_rate_r;
  logic [15:0] max_gap_r;
  logic [COUNTER_BITS-1:0] good_c, bad_c, lost_c, drop_c;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rate_r <= RATE_LIMIT_RST;
      max_gap_r  <= SEQ_GAP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MAX_RATE: max_rate_r <= cfg_ch.data[30:0];
        REG_MAX_GAP:  max_gap_r  <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  afr_core #(.COUNTER_BITS(COUNTER_BITS)) u_core (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_byte(in_ch.rx_byte),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_ok(out_ch.frame_accepted),
    .out_yaw(out_ch.yaw_x100), .out_rate(out_ch.rate_x100),
    .out_seq(out_ch.last_sequence),
    .out_good(good_c), .out_bad(bad_c), .out_lost(lost_c), .out_drop(drop_c),
    .max_rate(max_rate_r), .max_gap(max_gap_r)
  );

  assign out_ch.good_frames   = 32'(good_c);
  assign out_ch.bad_frames    = 32'(bad_c);
  assign out_ch.lost_frames   = 32'(lost_c);
  assign out_ch.dropped_bytes = 32'(drop_c);
endmodule

// File: rtl/afr_checker.sv
// Port-level checks for the attitude frame receiver, bound to the top level.
// Depends on afr_if.
module afr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_ok,
  input logic [31:0] good
);
  // No new byte while a result waits
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  // A result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // Accepted frame never leaves good count at zero
  a_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> good != 32'd0) else $error("good count not raised");

  // Ready falls after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
endmodule

bind attitude_frame_receiver afr_checker u_afr_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_ok(out_ch.frame_accepted), .good(out_ch.good_frames)
);

// File: tb/sv/tb.sv
// Self-checking testbench for attitude_frame_receiver: drives received bytes, frames
// and noise, predicts every result in place and compares field by field.
// Depends on afr_pkg, afr_if and the receiver RTL.
module tb;
  import afr_pkg::*;

  typedef logic [7:0] frame_t [16];

  typedef struct {
    logic        accepted;
    logic [31:0] yaw;
    logic [31:0] rate;
    logic [15:0] seq;
    logic [31:0] good;
    logic [31:0] bad;
    logic [31:0] lost;
    logic [31:0] dropped;
  } result_t;

  typedef struct {
    logic [7:0] b;
    bit         pinned;
    result_t    want;
  } row_t;

  localparam int NUM_ITEMS = 1400;
  localparam int SETTLE    = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  afr_in_if  in_ch ();
  afr_out_if out_ch ();
  afr_cfg_if cfg_ch ();

  attitude_frame_receiver u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // Receiver state as predicted
  logic [30:0] rate_cap;
  logic [15:0] gap_cap;
  logic [7:0]  hold_buf [16];
  logic [4:0]  fill;
  bit          synced;
  logic [15:0] prev_seq;
  logic [31:0] yaw_hold, rate_hold;
  logic [31:0] n_good, n_bad, n_lost, n_dropped;

  result_t result_q [$];
  int      errors = 0;
  int      items_sent = 0;
  bit      quiet_phase = 1'b0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [31:0] inc);
    logic [32:0] s;
    s = {1'b0, v} + {1'b0, inc};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Convert float bits to value x100, round half away from zero; bit 32 flags success
  function automatic logic [32:0] float_to_x100(input logic [31:0] bits,
                                                 input logic [31:0] limit);
    logic [63:0] mag, scaled;
    int          e, sh;
    mag = '0;
    if (bits[30:23] == 8'hFF) return '0;
    if (bits[30:23] != 8'h00) begin
      e = int'(bits[30:23]) - 127;
      scaled = {40'd0, 1'b1, bits[22:0]} * 64'd100;
      if (e >= 23) begin
        sh = e - 23;
        if (sh >= 32 || scaled > ({32'd0, limit} >> sh)) return '0;
        mag = scaled << sh;
      end else begin
        sh = 23 - e;
        if (sh < 64) begin
          scaled = scaled + (64'd1 << (sh - 1));
          mag = scaled >> sh;
        end
      end
    end
    if (mag > {32'd0, limit}) return '0;
    return {1'b1, bits[31] ? (32'd0 - mag[31:0]) : mag[31:0]};
  endfunction

  function automatic logic [15:0] crc16(input logic [7:0] f [16]);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 2; i < 12; i++) begin
      c = c ^ {8'd0, f[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic reset_model();
    rate_cap = RATE_LIMIT_RST;
    gap_cap = SEQ_GAP_RST;
    foreach (hold_buf[i]) hold_buf[i] = '0;
    fill = '0;
    synced = 1'b0;
    prev_seq = '0;
    yaw_hold = '0;
    rate_hold = '0;
    {n_good, n_bad, n_lost, n_dropped} = '0;
  endtask

  // Check the complete frame in the store and commit it if good
  function automatic bit take_frame();
    logic [32:0] yv, rv;
    logic [15:0] sq, d;
    if (hold_buf[0] != HEAD_A || hold_buf[1] != HEAD_B ||
        hold_buf[14] != TAIL_A || hold_buf[15] != TAIL_B) return 1'b0;
    if ({hold_buf[13], hold_buf[12]} != crc16(hold_buf)) return 1'b0;
    yv = float_to_x100({hold_buf[7], hold_buf[6], hold_buf[5], hold_buf[4]}, YAW_LIMIT);
    if (!yv[32]) return 1'b0;
    rv = float_to_x100({hold_buf[11], hold_buf[10], hold_buf[9], hold_buf[8]},
                       {1'b0, rate_cap});
    if (!rv[32]) return 1'b0;
    sq = {hold_buf[3], hold_buf[2]};
    if (synced) begin
      d = sq - prev_seq;
      if (d > 16'd1 && d <= gap_cap) n_lost = sat_add(n_lost, {16'd0, d} - 32'd1);
    end
    synced = 1'b1;
    yaw_hold = yv[31:0];
    rate_hold = rv[31:0];
    prev_seq = sq;
    n_good = sat_add(n_good, 1);
    return 1'b1;
  endfunction

  // Realign after a rejected frame: drop on intact tail, else keep from last head pair or a final head byte
  function automatic void realign();
    if (hold_buf[14] == TAIL_A && hold_buf[15] == TAIL_B) begin
      fill = 0;
      return;
    end
    for (int s = 14; s > 0; s--) begin
      if (hold_buf[s] == HEAD_A && hold_buf[s + 1] == HEAD_B) begin
        for (int i = 0; i < 16 - s; i++) hold_buf[i] = hold_buf[s + i];
        fill = 5'(16 - s);
        return;
      end
    end
    if (hold_buf[15] == HEAD_A) begin
      hold_buf[0] = HEAD_A;
      fill = 1;
    end else begin
      fill = 0;
    end
  endfunction

  function automatic result_t predict_byte(input logic [7:0] b);
    result_t r;
    logic [3:0] pos;
    bit ok;
    ok = 1'b0;
    pos = fill[3:0];
    if (pos == 0) begin
      if (b == HEAD_A) begin
        hold_buf[0] = b;
        fill = 1;
      end else begin
        n_dropped = sat_add(n_dropped, 1);
      end
    end else if (pos == 1) begin
      if (b == HEAD_B) begin
        hold_buf[1] = b;
        fill = 2;
      end else begin
        n_dropped = sat_add(n_dropped, 1);
        if (b == HEAD_A) begin
          hold_buf[0] = b;
          fill = 1;
        end else begin
          fill = 0;
          n_dropped = sat_add(n_dropped, 1);
        end
      end
    end else begin
      hold_buf[pos] = b;
      if (pos != 15) begin
        fill = 5'(pos) + 5'd1;
      end else if (take_frame()) begin
        fill = 0;
        ok = 1'b1;
      end else begin
        n_bad = sat_add(n_bad, 1);
        realign();
      end
    end
    r.accepted = ok;
    r.yaw = yaw_hold;
    r.rate = rate_hold;
    r.seq = prev_seq;
    r.good = n_good;
    r.bad = n_bad;
    r.lost = n_lost;
    r.dropped = n_dropped;
    return r;
  endfunction

  function automatic frame_t build_frame(input logic [15:0] sq, input logic [31:0] yb,
                                         input logic [31:0] rb);
    frame_t f;
    logic [15:0] c;
    f[0] = HEAD_A;  f[1] = HEAD_B;
    f[2] = sq[7:0]; f[3] = sq[15:8];
    for (int i = 0; i < 4; i++) begin
      f[4 + i] = yb[8 * i +: 8];
      f[8 + i] = rb[8 * i +: 8];
    end
    c = crc16(f);
    f[12] = c[7:0]; f[13] = c[15:8];
    f[14] = TAIL_A; f[15] = TAIL_B;
    return f;
  endfunction

  // Float bit patterns weighted towards the decode limits and rounding corners
  function automatic logic [31:0] pick_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: ;
      3: begin
        v[30:23] = 8'($urandom_range(119, 127));
        v[15:0] = '0;
      end
      default: v[30:23] = 8'($urandom_range(114, 156));
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one byte; valid stays high straight into the next transfer when no gap
  task automatic send_byte(input logic [7:0] b, input bit pinned, input result_t want);
    int gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_byte(b);
    result_q.push_back(pinned ? want : r);
    items_sent++;
  endtask

  task automatic send_plain(input logic [7:0] b);
    result_t none;
    none = '{default: '0};
    send_byte(b, 1'b0, none);
  endtask

  // Hold valid high after the transfer; the caller drops it once the writes are done
  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_MAX_RATE) rate_cap = value[30:0];
    else gap_cap = value[15:0];
  endtask

  // Wait for every expected result, then let any frame work still running finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic result_t counts(input bit acc, input logic [15:0] sq,
                                     input logic [31:0] good, input logic [31:0] dropped);
    result_t r;
    r = '{default: '0};
    r.accepted = acc;
    r.seq = sq;
    r.good = good;
    r.dropped = dropped;
    return r;
  endfunction

  // Result side: random stalls, compare each transfer with the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.accepted = out_ch.frame_accepted;
        got.yaw = out_ch.yaw_x100;
        got.rate = out_ch.rate_x100;
        got.seq = out_ch.last_sequence;
        got.good = out_ch.good_frames;
        got.bad = out_ch.bad_frames;
        got.lost = out_ch.lost_frames;
        got.dropped = out_ch.dropped_bytes;
        if (result_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = result_q.pop_front();
          if (got.accepted !== want.accepted)
            report($sformatf("frame_accepted %0b want %0b", got.accepted, want.accepted));
          if (got.yaw !== want.yaw)
            report($sformatf("yaw_x100 %h want %h", got.yaw, want.yaw));
          if (got.rate !== want.rate)
            report($sformatf("rate_x100 %h want %h", got.rate, want.rate));
          if (got.seq !== want.seq)
            report($sformatf("last_sequence %h want %h", got.seq, want.seq));
          if (got.good !== want.good)
            report($sformatf("good_frames %0d want %0d", got.good, want.good));
          if (got.bad !== want.bad)
            report($sformatf("bad_frames %0d want %0d", got.bad, want.bad));
          if (got.lost !== want.lost)
            report($sformatf("lost_frames %0d want %0d", got.lost, want.lost));
          if (got.dropped !== want.dropped)
            report($sformatf("dropped_bytes %0d want %0d", got.dropped, want.dropped));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet_phase) stall_left <= pick_gap();
      end
    end
  end

  initial begin
    #(12 * 4_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    row_t        rows [$];
    frame_t      f;
    logic [15:0] seq;
    logic [31:0] rate_opts [4];
    logic [15:0] gap_opts [4];
    int          cut, phase;

    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: hunting the head, then a zero-valued frame and a stray byte
    rows.push_back('{8'h00, 1'b1, counts(0, 16'h0000, 0, 1)});
    rows.push_back('{HEAD_A, 1'b0, counts(0, 0, 0, 0)});
    rows.push_back('{8'h12, 1'b1, counts(0, 16'h0000, 0, 3)});
    rows.push_back('{HEAD_A, 1'b0, counts(0, 0, 0, 0)});
    rows.push_back('{HEAD_A, 1'b1, counts(0, 16'h0000, 0, 4)});
    f = build_frame(16'h0102, 32'h0000_0000, 32'h8000_0000);
    for (int i = 1; i < 15; i++) rows.push_back('{f[i], 1'b0, counts(0, 0, 0, 0)});
    rows.push_back('{f[15], 1'b1, counts(1, 16'h0102, 1, 4)});
    rows.push_back('{HEAD_B, 1'b1, counts(0, 16'h0102, 1, 5)});
    foreach (rows[i]) send_byte(rows[i].b, rows[i].pinned, rows[i].want);
    drain();

    rate_opts = '{32'd0, 32'h7FFF_FFFF, 32'd400000, 32'($urandom_range(1, 2000000))};
    gap_opts = '{16'd1, 16'd65535, 16'd32767, 16'($urandom_range(2, 40))};
    seq = 16'h0102;
    phase = 0;
    // Random: mostly well-formed frames with random content, plus damage and noise, with new limits written per phase
    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= 30 + phase * 340 && phase < 4) begin
        drain();
        write_reg(REG_MAX_RATE, rate_opts[phase]);
        write_reg(REG_MAX_GAP, {16'd0, gap_opts[phase]});
        cfg_ch.valid <= 1'b0;
        quiet_phase = (phase == 2);
        phase++;
      end
      case ($urandom_range(0, 9))
        0: seq = 16'($urandom);
        1: seq = seq + 16'($urandom_range(2, 50));
        2: ;
        default: seq = seq + 16'd1;
      endcase
      f = build_frame(seq, pick_float(), pick_float());
      if ($urandom_range(0, 6) == 0) f[$urandom_range(2, 15)] ^= 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) f[$urandom_range(2, 15)] = HEAD_A;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 16;
      for (int i = 0; i < cut; i++) send_plain(f[i]);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4)) send_plain(($urandom_range(0, 2) == 0) ?
                                                 HEAD_A : 8'($urandom));
    end
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/afr_pkg.sv
rtl/afr_if.sv
rtl/afr_fconv.sv
rtl/afr_core.sv
rtl/attitude_frame_receiver.sv
rtl/afr_checker.sv
tb/sv/tb.sv
